// File: rtl/zcsf_pkg.sv
// Shared widths, register indexes, reset values and the response record
// of the zero-crossing segment finder. No dependencies.
package zcsf_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int INDEX_BITS  = 16;
   localparam int LEN_BITS    = 16;
   localparam int CFG_BITS    = 16;
   localparam int CSR_IDX_BITS = 1;
   // Width that holds any index, register value or index plus one.
   localparam int CMP_BITS    = 33;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_TOTAL_SAMPLES = 1'b0,
      CSR_MIN_SPACING   = 1'b1
   } csr_index_type;

   localparam logic [CFG_BITS-1:0] TOTAL_SAMPLES_RESET = CFG_BITS'(1024);
   localparam logic [CFG_BITS-1:0] MIN_SPACING_RESET   = CFG_BITS'(100);

   typedef struct packed {
      logic [CFG_BITS-1:0] total_samples;
      logic [CFG_BITS-1:0] min_spacing;
   } cfg_type;

   typedef struct packed {
      logic                found;
      logic [LEN_BITS-1:0] span_len;
   } rsp_type;

endpackage

// File: rtl/zcsf_step.sv
// Per-sample crossing test, run state registers and result decision.
// Depends on zcsf_pkg.
module zcsf_step
   import zcsf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  cfg_type                cfg,
   output logic                   rsp_push,
   output rsp_type                rsp_data
);

   logic [SAMPLE_BITS-1:0] prev_ff, prev_in;
   logic [INDEX_BITS-1:0]  index_ff, index_in;
   logic [INDEX_BITS-1:0]  first_ff, first_in;
   logic [INDEX_BITS-1:0]  second_ff, second_in;
   logic [1:0]             taken_ff, taken_in;
   logic                   sent_ff, sent_in;

   logic                   is_cross;
   logic                   check;
   logic [INDEX_BITS-1:0]  pos;
   logic [INDEX_BITS-1:0]  dist_first;
   logic [INDEX_BITS-1:0]  dist_second;
   logic                   far_first;
   logic                   far_second;
   logic                   hit;
   logic                   last;

   always_comb begin
      is_cross = (prev_ff == '0) || (sample == '0) ||
                 (prev_ff[SAMPLE_BITS-1] != sample[SAMPLE_BITS-1]);
      check = (index_ff != '0) && !sent_ff && is_cross;
      pos = index_ff - INDEX_BITS'(1);
      dist_first  = pos - first_ff;
      dist_second = pos - second_ff;
      far_first  = CMP_BITS'(dist_first)  >= CMP_BITS'(cfg.min_spacing);
      far_second = CMP_BITS'(dist_second) >= CMP_BITS'(cfg.min_spacing);
      hit = check && (taken_ff == 2'd2) && far_second;
      last = (CMP_BITS'(index_ff) + CMP_BITS'(1) >= CMP_BITS'(cfg.total_samples)) ||
             (index_ff == '1);

      rsp_push = fire && (hit || (last && !sent_ff));
      rsp_data.found = hit;
      rsp_data.span_len = hit ? LEN_BITS'(dist_first + INDEX_BITS'(1)) : '0;

      prev_in   = prev_ff;
      index_in  = index_ff;
      first_in  = first_ff;
      second_in = second_ff;
      taken_in  = taken_ff;
      sent_in   = sent_ff;
      if (fire) begin
         if (last) begin
            // Start a new run.
            prev_in   = '0;
            index_in  = '0;
            first_in  = '0;
            second_in = '0;
            taken_in  = '0;
            sent_in   = 1'b0;
         end else begin
            prev_in  = sample;
            index_in = index_ff + INDEX_BITS'(1);
            if (hit) begin
               sent_in = 1'b1;
            end else if (check && taken_ff == 2'd0) begin
               first_in = pos;
               taken_in = 2'd1;
            end else if (check && taken_ff == 2'd1 && far_first) begin
               second_in = pos;
               taken_in  = 2'd2;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         index_ff  <= '0;
         first_ff  <= '0;
         second_ff <= '0;
         taken_ff  <= '0;
         sent_ff   <= 1'b0;
      end else begin
         prev_ff   <= prev_in;
         index_ff  <= index_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         taken_ff  <= taken_in;
         sent_ff   <= sent_in;
      end
   end

endmodule

// File: rtl/zcsf_rsp_fifo.sv
// Two-entry response buffer between the step logic and the rsp channel.
// Depends on zcsf_pkg.
module zcsf_rsp_fifo
   import zcsf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   rsp_type    mem_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       pop;

   always_comb begin
      full      = (count_ff == 2'd2);
      out_valid = (count_ff != 2'd0);
      out_data  = mem_ff[rd_ptr_ff];
      pop       = out_valid && out_ready;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/zero_crossing_segment_finder_core.sv
// Zero-crossing segment finder: top level with request register, step logic,
// response buffer and CSRs. Depends on zcsf_pkg, zcsf_step, zcsf_rsp_fifo.
//
// Usage:
//   req channel carries one signed sample per request. A run is
//   total_samples requests long. A crossing sits at position k-1 when
//   sample k-1 or k is zero or the two differ in sign. The first crossing
//   is always taken, the second and third only min_spacing or more
//   positions after the one before.
//   rsp channel returns one response per run: tuser=1 with the length from
//   first to third crossing inclusive as soon as the third is seen (the rest
//   of the run is then dropped), or tuser=0 and length 0 on the last sample.
//   csr port writes total_samples (index 0) or min_spacing (index 1); write
//   only while the block is idle.
// Timing:
//   A request is registered, evaluated by the step logic once the response
//   buffer has room, and its response is registered in a two-entry buffer
//   that drives rsp_tvalid. One request per cycle is taken for as long as
//   the buffer has room; a stalled receiver fills the buffer and then holds
//   req_tready low, with no combinational path from rsp_tready to
//   req_tready.
// Reset:
//   Clears the run state and buffer, and loads total_samples=1024 and
//   min_spacing=100.
module zero_crossing_segment_finder_core
   import zcsf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // request: [15:0] sample
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [SAMPLE_BITS-1:0]  req_tdata,
   // response: [15:0] span_len
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [LEN_BITS-1:0]     rsp_tdata,
   // response: [0] found
   output logic                    rsp_tuser,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_wdata
);

   cfg_type                cfg_ff, cfg_in;
   logic                   in_valid_ff, in_valid_in;
   logic [SAMPLE_BITS-1:0] in_sample_ff, in_sample_in;
   logic                   fifo_full;
   logic                   advance;
   logic                   req_fire;
   logic                   step_push;
   rsp_type                step_rsp;
   rsp_type                out_rsp;

   // Configuration writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TOTAL_SAMPLES: cfg_in.total_samples = csr_wdata;
            CSR_MIN_SPACING:   cfg_in.min_spacing   = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.total_samples <= TOTAL_SAMPLES_RESET;
         cfg_ff.min_spacing   <= MIN_SPACING_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Request register: advance it into the step logic whenever the
   // response buffer has room; refill it in the same cycle.
   always_comb begin
      advance      = in_valid_ff && !fifo_full;
      req_tready   = !in_valid_ff || !fifo_full;
      req_fire     = req_tvalid && req_tready;
      in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_sample_in = req_fire ? req_tdata : in_sample_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_sample_ff <= in_sample_in;
   end

   zcsf_step u_step (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .sample   (in_sample_ff),
      .cfg      (cfg_ff),
      .rsp_push (step_push),
      .rsp_data (step_rsp)
   );

   zcsf_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (step_push),
      .push_data (step_rsp),
      .full      (fifo_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_rsp)
   );

   assign rsp_tdata = out_rsp.span_len;
   assign rsp_tuser = out_rsp.found;

endmodule

// File: rtl/zcsf_checker.sv
// Port-level checks for the zero-crossing segment finder, bound to the top.
// Depends on zcsf_pkg and zero_crossing_segment_finder_core.
module zcsf_checker
   import zcsf_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [LEN_BITS-1:0]     rsp_tdata,
   input logic                    rsp_tuser
);

   // Hold a stalled response.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // A run that ends without three crossings reports length zero.
   a_miss_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("not-found response with nonzero length");

   // A found segment spans at least one sample.
   a_hit_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata != '0)
      else $error("found response with zero length");

   // Reset empties the response buffer.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response pending right after reset");

endmodule

bind zero_crossing_segment_finder_core zcsf_checker u_zcsf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: verif/zero_crossing_segment_finder_core_tb.sv
// Self-checking bench for zero_crossing_segment_finder_core: a segment tracker
// predicts each run's response and checks the response stream in order.
// Depends on zcsf_pkg and the core; needs no files or arguments.
`timescale 1ns / 100ps

module zero_crossing_segment_finder_core_tb;
   import zcsf_pkg::*;

   localparam int RESET_CYCLES    = 11;
   // Margin for the pipeline to drain after the last owed response.
   localparam int SETTLE_CYCLES   = 8;
   localparam int CYCLE_LIMIT     = 300000;
   localparam int RANDOM_SETS     = 8;
   localparam int SAMPLES_PER_SET = 50;
   localparam int PRINT_CAP       = 40;

   // Tracks the run state of the finder and holds the responses still owed.
   class segment_tracker;
      logic [CFG_BITS-1:0]    run_length;
      logic [CFG_BITS-1:0]    spacing;
      logic [SAMPLE_BITS-1:0] prev_sample;
      logic [INDEX_BITS-1:0]  run_index;
      logic [INDEX_BITS-1:0]  first_pos;
      logic [INDEX_BITS-1:0]  second_pos;
      int unsigned            taken;
      bit                     segment_done;
      rsp_type                owed_segments[$];
      int unsigned            failures;

      function new();
         run_length = TOTAL_SAMPLES_RESET;
         spacing    = MIN_SPACING_RESET;
         failures   = 0;
         restart_run();
      endfunction

      function void restart_run();
         prev_sample  = '0;
         run_index    = '0;
         first_pos    = '0;
         second_pos   = '0;
         taken        = 0;
         segment_done = 1'b0;
      endfunction

      function void set_register(csr_index_type idx, logic [CFG_BITS-1:0] value);
         case (idx)
            CSR_TOTAL_SAMPLES: run_length = value;
            CSR_MIN_SPACING:   spacing = value;
            default: ;
         endcase
      endfunction

      function void take_sample(logic [SAMPLE_BITS-1:0] cur);
         logic [INDEX_BITS-1:0] pos;
         logic [INDEX_BITS-1:0] gap;
         logic                  crossing;
         logic                  run_over;
         rsp_type               seg;
         if (run_index != '0 && !segment_done) begin
            crossing = (prev_sample == '0) || (cur == '0) ||
                       (prev_sample[SAMPLE_BITS-1] != cur[SAMPLE_BITS-1]);
            pos = run_index - 1'b1;
            if (crossing) begin
               if (taken == 0) begin
                  first_pos = pos;
                  taken = 1;
               end else if (taken == 1) begin
                  gap = pos - first_pos;
                  if (gap >= spacing) begin
                     second_pos = pos;
                     taken = 2;
                  end
               end else begin
                  gap = pos - second_pos;
                  if (gap >= spacing) begin
                     seg.found = 1'b1;
                     seg.span_len = pos - first_pos + 1'b1;
                     owed_segments.push_back(seg);
                     segment_done = 1'b1;
                  end
               end
            end
         end
         run_over = (32'(run_index) + 1 >= 32'(run_length)) || (run_index == '1);
         if (run_over) begin
            if (!segment_done) begin
               seg.found = 1'b0;
               seg.span_len = '0;
               owed_segments.push_back(seg);
            end
            restart_run();
         end else begin
            run_index   = run_index + 1'b1;
            prev_sample = cur;
         end
      endfunction

      function void check_segment(logic found, logic [LEN_BITS-1:0] seg_len);
         rsp_type want;
         if (owed_segments.size() == 0) begin
            failures++;
            if (failures <= PRINT_CAP)
               $display("%0t: unexpected response, expected none, got found=%0b length=%0d",
                        $time, found, seg_len);
         end else begin
            want = owed_segments.pop_front();
            if (found !== want.found) begin
               failures++;
               if (failures <= PRINT_CAP)
                  $display("%0t: found mismatch, expected %0b, got %0b",
                           $time, want.found, found);
            end
            if (seg_len !== want.span_len) begin
               failures++;
               if (failures <= PRINT_CAP)
                  $display("%0t: span_len mismatch, expected %0d, got %0d",
                           $time, want.span_len, seg_len);
            end
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [SAMPLE_BITS-1:0]  req_tdata;   // [15:0] sample
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [LEN_BITS-1:0]     rsp_tdata;   // [15:0] span_len
   logic                    rsp_tuser;   // [0] found
   logic                    csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CFG_BITS-1:0]     csr_wdata;

   segment_tracker tracker;
   int unsigned    sender_idle_pct;
   int unsigned    receiver_idle_pct;
   int unsigned    cycle_count = 0;
   // Shape of the random waveform: current polarity and how often it flips.
   bit             wave_positive;
   int unsigned    flip_odds;

   zero_crossing_segment_finder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case a response never shows up or the request side hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Response side: check what was taken at this edge (values read here are
   // the ones present at the edge), then pick the ready for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_segment(rsp_tuser, rsp_tdata);
      rsp_tready <= (receiver_idle_pct == 0) || ($urandom_range(99) >= receiver_idle_pct);
   end

   // Offer one request, idling first at random, and hold it until accepted.
   // Valid stays high on return so back-to-back requests need no second edit.
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do begin
         @(posedge clock);
      end while (!req_tready);
      tracker.take_sample(value);
   endtask

   // Drop valid and wait until every owed response is back, then give the
   // pipeline time to retire requests that produce no response.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.owed_segments.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers while the core is idle.
   task automatic apply_settings(input logic [CFG_BITS-1:0] run_len,
                                 input logic [CFG_BITS-1:0] min_gap);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_TOTAL_SAMPLES;
      csr_wdata <= run_len;
      @(posedge clock);
      tracker.set_register(CSR_TOTAL_SAMPLES, run_len);
      csr_index <= CSR_MIN_SPACING;
      csr_wdata <= min_gap;
      @(posedge clock);
      tracker.set_register(CSR_MIN_SPACING, min_gap);
      csr_we <= 1'b0;
   endtask

   // Mostly a square-ish wave with random amplitude and random polarity flips,
   // salted with zeros, full-scale values and raw noise.
   function automatic logic [SAMPLE_BITS-1:0] next_sample();
      int unsigned            pick;
      logic [SAMPLE_BITS-1:0] mag;
      pick = $urandom_range(99);
      if (pick < 8)
         return '0;
      if (pick < 12) begin
         case ($urandom_range(3))
            0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            2: return SAMPLE_BITS'(1);
            default: return '1;
         endcase
      end
      if (pick < 20)
         return SAMPLE_BITS'($urandom);
      if ($urandom_range(flip_odds - 1) == 0)
         wave_positive = !wave_positive;
      mag = SAMPLE_BITS'($urandom_range(1, (1 << (SAMPLE_BITS - 1)) - 1));
      return wave_positive ? mag : -mag;
   endfunction

   initial begin
      logic [CFG_BITS-1:0] run_len;
      logic [CFG_BITS-1:0] min_gap;
      tracker           = new();
      sender_idle_pct   = 22;
      receiver_idle_pct = 83;
      wave_positive     = 1'b1;
      flip_odds         = 4;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= CSR_TOTAL_SAMPLES;
      csr_wdata  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Full-scale positive to full-scale negative, then zeros: three
      // crossings back to back with no spacing; the tail is swallowed.
      apply_settings(16'd6, 16'd0);
      send_sample(16'h7fff);
      send_sample(16'h8000);
      send_sample(16'h0000);
      send_sample(16'h0000);
      send_sample(16'h0001);
      send_sample(16'hffff);

      // One-sample run: nothing can precede the sample, so no crossing.
      apply_settings(16'd1, 16'hffff);
      send_sample(16'd5);
      // Zero run length behaves as one.
      apply_settings(16'd0, 16'hffff);
      send_sample(-16'sd3);
      // Widest spacing: only the first crossing is ever taken.
      apply_settings(16'd4, 16'hffff);
      send_sample(16'd1);
      send_sample(-16'sd1);
      send_sample(16'd1);
      send_sample(-16'sd1);

      // Gaps exactly at the spacing pass, a shorter one is skipped, and the
      // third crossing lands on the last sample of the run.
      apply_settings(16'd8, 16'd3);
      send_sample(16'd5);
      send_sample(-16'sd5);
      send_sample(-16'sd5);
      send_sample(-16'sd5);
      send_sample(16'd5);
      send_sample(-16'sd5);
      send_sample(-16'sd5);
      send_sample(16'd5);

      // Longest run; then shorten it mid-run so the next sample closes it.
      apply_settings(16'hffff, 16'd0);
      repeat (4) send_sample(16'h0000);
      apply_settings(16'd2, 16'd0);
      send_sample(16'd9);

      // Random runs in three idling regimes, new settings for every set.
      for (int mode = 0; mode < 3; mode++) begin
         sender_idle_pct   = (mode == 0) ? 22 : (mode == 1) ? 83 : 0;
         receiver_idle_pct = (mode == 0) ? 83 : (mode == 1) ? 22 : 0;
         for (int set_no = 0; set_no < RANDOM_SETS; set_no++) begin
            run_len   = ($urandom_range(9) == 0) ? 16'd1 : CFG_BITS'($urandom_range(2, 32));
            min_gap   = CFG_BITS'($urandom_range(0, 10));
            flip_odds = $urandom_range(2, 12);
            apply_settings(run_len, min_gap);
            repeat (SAMPLES_PER_SET) send_sample(next_sample());
         end
      end

      settle();
      if (tracker.failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: sim.f
rtl/zcsf_pkg.sv
rtl/zcsf_step.sv
rtl/zcsf_rsp_fifo.sv
rtl/zero_crossing_segment_finder_core.sv
rtl/zcsf_checker.sv
verif/zero_crossing_segment_finder_core_tb.sv
